@@ rtl/bffa_pkg.sv @@
// bffa_pkg: constants, request codes and sequencer states of the
// bitmap first-fit allocator; no dependencies
package bffa_pkg;

  localparam int unsigned POOL_BYTES = 4096;
  localparam int unsigned ALIGN      = 4;
  localparam int unsigned AW         = $clog2(POOL_BYTES);
  localparam int unsigned CW         = AW + 1;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_ARD,
    ST_AEV,
    ST_MARK,
    ST_FRD,
    ST_FEV
  } state_e;

endpackage

@@ rtl/bitmap_first_fit_allocator_core.sv @@
// bitmap_first_fit_allocator_core: busy map in a one-bit-wide memory,
// walked by a small sequencer with one shared scan compare; uses bffa_pkg
//
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | req_type_i, alloc_size_i, start_offset_i
// out     | output    | out_valid_o/out_ready_i | ok_o, block_offset_o, freed_count_o
// cfg     | input     | cfg_we_i              | cfg_wdata_i (pool_size)
//
// allocate: reads and tests each map byte up to the fit, then marks
// alloc_size bytes and returns the result; free: releases busy bytes from
// start_offset until a free byte or the pool end, then returns the count
// clear request and reset: a sweep over the whole map memory,
// no beat accepted meanwhile; one request at a time, one map port
// a waiting result beat holds off the next request
module bitmap_first_fit_allocator_core
  import bffa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    req_type_i,
  input  logic [CW-1:0] alloc_size_i,
  input  logic [AW-1:0] start_offset_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          ok_o,
  output logic [AW-1:0] block_offset_o,
  output logic [CW-1:0] freed_count_o,
  input  logic          cfg_we_i,
  input  logic [12:0]   cfg_wdata_i
);

  state_e        state_q, state_d;
  logic [12:0]   pool_size_q;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] size_q, size_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] cand_q, cand_d;
  logic          cand_v_q, cand_v_d;
  logic          prev_q, prev_d;
  logic          resp_q, resp_d;
  logic          out_valid_q, out_valid_d;
  logic          ok_q, ok_d;
  logic [AW-1:0] off_q, off_d;
  logic [CW-1:0] freed_q, freed_d;

  logic          mem [POOL_BYTES];
  logic          rdata_q;
  logic          mem_we, mem_wd;
  logic [AW-1:0] mem_wa;

  logic          in_acc;
  logic [CW-1:0] pool_n;
  logic          aligned, start_c, cvn, ends_past, last, hit, a_fail;
  logic [CW-1:0] cntn;
  logic [CW:0]   size_p1;
  logic          sweep_end;

  assign in_acc    = in_valid_i && in_ready_o;
  assign pool_n    = (pool_size_q > 13'(POOL_BYTES)) ? CW'(POOL_BYTES) : CW'(pool_size_q);
  assign aligned   = (k_q % CW'(ALIGN)) == '0;
  assign start_c   = !cand_v_q && aligned && !prev_q && !rdata_q;
  assign cvn       = start_c || (cand_v_q && !rdata_q);
  assign cntn      = start_c ? CW'(1) : cnt_q + CW'(1);
  assign ends_past = ({1'b0, k_q} + {1'b0, size_q}) > {1'b0, n_q};
  assign last      = (k_q + CW'(1)) == n_q;
  assign size_p1   = {1'b0, size_q} + (CW+1)'(1);
  assign hit       = cvn && (({1'b0, cntn} == size_p1) || ((cntn == size_q) && last));
  assign a_fail    = (start_c && ends_past) || (!hit && last);
  assign sweep_end = k_q == CW'(POOL_BYTES - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_ALLOC: state_d = (pool_n == '0) ? ST_IDLE : ST_ARD;
            REQ_FREE:  state_d = ({1'b0, start_offset_i} >= pool_n) ? ST_IDLE : ST_FRD;
            REQ_CLEAR: state_d = ST_CLR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ARD: state_d = ST_AEV;
      ST_AEV: begin
        if (a_fail)   state_d = ST_IDLE;
        else if (hit) state_d = ST_MARK;
        else          state_d = ST_ARD;
      end
      ST_MARK: begin
        if (cnt_q == '0) state_d = ST_IDLE;
      end
      ST_FRD: state_d = (k_q >= n_q) ? ST_IDLE : ST_FEV;
      ST_FEV: state_d = rdata_q ? ST_FRD : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // map port and handshake
  always_comb begin
    mem_we = 1'b0;
    mem_wd = 1'b0;
    mem_wa = k_q[AW-1:0];
    case (state_q)
      ST_CLR:  mem_we = 1'b1;
      ST_MARK: begin
        mem_we = cnt_q != '0;
        mem_wd = 1'b1;
      end
      ST_FEV:  mem_we = rdata_q;
      default: mem_we = 1'b0;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;

  // datapath
  always_comb begin
    k_d         = k_q;
    size_d      = size_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    cand_d      = cand_q;
    cand_v_d    = cand_v_q;
    prev_d      = prev_q;
    resp_d      = resp_q;
    ok_d        = ok_q;
    off_d       = off_q;
    freed_d     = freed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLR: begin
        k_d = k_q + CW'(1);
        if (sweep_end) begin
          k_d = '0;
          if (resp_q) begin
            resp_d      = 1'b0;
            ok_d        = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          size_d   = alloc_size_i;
          n_d      = pool_n;
          k_d      = '0;
          cnt_d    = '0;
          cand_v_d = 1'b0;
          prev_d   = 1'b0;
          ok_d     = 1'b0;
          off_d    = '0;
          freed_d  = '0;
          case (req_type_i)
            REQ_ALLOC: begin
              if (pool_n == '0) out_valid_d = 1'b1;
            end
            REQ_FREE: begin
              k_d = {1'b0, start_offset_i};
              if ({1'b0, start_offset_i} >= pool_n) begin
                ok_d        = 1'b1;
                out_valid_d = 1'b1;
              end
            end
            REQ_CLEAR: resp_d = 1'b1;
            default:   out_valid_d = 1'b1;
          endcase
        end
      end
      ST_AEV: begin
        if (a_fail) begin
          out_valid_d = 1'b1;
        end else if (hit) begin
          off_d = start_c ? k_q[AW-1:0] : cand_q;
          k_d   = start_c ? k_q : {1'b0, cand_q};
          cnt_d = size_q;
          ok_d  = 1'b1;
        end else begin
          k_d      = k_q + CW'(1);
          prev_d   = rdata_q;
          cand_v_d = cvn;
          cnt_d    = cntn;
          if (start_c) cand_d = k_q[AW-1:0];
        end
      end
      ST_MARK: begin
        if (cnt_q == '0) begin
          out_valid_d = 1'b1;
        end else begin
          k_d   = k_q + CW'(1);
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_FRD: begin
        if (k_q >= n_q) begin
          ok_d        = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      ST_FEV: begin
        if (rdata_q) begin
          k_d     = k_q + CW'(1);
          freed_d = freed_q + CW'(1);
        end else begin
          ok_d        = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      pool_size_q <= 13'(POOL_BYTES);
      k_q         <= '0;
      resp_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cand_v_q    <= 1'b0;
      prev_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      resp_q      <= resp_d;
      out_valid_q <= out_valid_d;
      cand_v_q    <= cand_v_d;
      prev_q      <= prev_d;
      if (cfg_we_i) pool_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    n_q     <= n_d;
    cnt_q   <= cnt_d;
    cand_q  <= cand_d;
    ok_q    <= ok_d;
    off_q   <= off_d;
    freed_q <= freed_d;
  end

  // busy map
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[k_q[AW-1:0]];
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign block_offset_o = off_q;
  assign freed_count_o  = freed_q;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == ST_IDLE) && !out_valid_q)
    else $error("ready outside idle");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (block_offset_o == '0) && (freed_count_o == '0))
    else $error("failed beat carries data");
  a_mark_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK && cnt_q != '0) |-> k_q < n_q)
    else $error("mark beyond pool end");
  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ARD || state_q == ST_AEV || state_q == ST_FEV) |-> !out_valid_q)
    else $error("result during work");
`endif

endmodule

@@ test/tb_bitmap_first_fit_allocator_core.sv @@
// tb_bitmap_first_fit_allocator_core: drives requests and pool size writes into the
// allocator core, predicts each result from a local busy map and checks every beat;
// depends on bffa_pkg and bitmap_first_fit_allocator_core
`timescale 1ns / 1ps

module tb_bitmap_first_fit_allocator_core;
  import bffa_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic          ok;
    logic [AW-1:0] offs;
    logic [CW-1:0] count;
  } alloc_result_t;

  class alloc_scoreboard;
    bit            busy[POOL_BYTES];
    logic [12:0]   pool_reg;
    alloc_result_t pending_q[$];
    int            mismatches;
    int            results_seen;

    function void set_pool(logic [12:0] v);
      pool_reg = v;
    endfunction

    function int unsigned usable();
      return (pool_reg > POOL_BYTES) ? POOL_BYTES : pool_reg;
    endfunction

    function bit first_fit(int unsigned size, output int unsigned where);
      int unsigned run[POOL_BYTES + 1];
      int unsigned n;
      n = usable();
      run[n] = 0;
      for (int unsigned i = n; i > 0; i--) run[i-1] = busy[i-1] ? 0 : run[i] + 1;
      for (int unsigned i = 0; i < n; i += ALIGN) begin
        if (i > 0 && busy[i-1]) continue;
        if (i + size > n) break;
        if (run[i] < size) continue;
        if (i + size < n && run[i] < size + 1) continue;
        if (size == 0 && busy[i]) continue;
        where = i;
        return 1;
      end
      return 0;
    endfunction

    function alloc_result_t note_request(logic [1:0] req, logic [CW-1:0] size,
                                         logic [AW-1:0] start);
      alloc_result_t r;
      int unsigned   at;
      int unsigned   n;
      r = '0;
      n = usable();
      if (req == REQ_ALLOC) begin
        if (first_fit(size, at)) begin
          for (int unsigned k = 0; k < size; k++) busy[at+k] = 1;
          r.ok = 1;
          r.offs = AW'(at);
        end
      end else if (req == REQ_FREE) begin
        for (int unsigned k = start; k < n && busy[k]; k++) begin
          busy[k] = 0;
          r.count++;
        end
        r.ok = 1;
      end else if (req == REQ_CLEAR) begin
        foreach (busy[k]) busy[k] = 0;
        r.ok = 1;
      end
      pending_q.push_back(r);
      return r;
    endfunction

    function void check_result(logic ok, logic [AW-1:0] offs, logic [CW-1:0] count);
      alloc_result_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat ok=%0d off=%0d cnt=%0d",
                                       ok, offs, count);
        return;
      end
      want = pending_q.pop_front();
      if (ok !== want.ok || offs !== want.offs || count !== want.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected ok=%0d off=%0d cnt=%0d, got ok=%0d off=%0d cnt=%0d",
                   want.ok, want.offs, want.count, ok, offs, count);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [1:0]    req_type_i;
  logic [CW-1:0] alloc_size_i;
  logic [AW-1:0] start_offset_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic          ok_o;
  logic [AW-1:0] block_offset_o;
  logic [CW-1:0] freed_count_o;
  logic          cfg_we_i;
  logic [12:0]   cfg_wdata_i;

  alloc_scoreboard sb;
  bit              quiet;
  int              items_sent;
  int              live_offs[$];

  bitmap_first_fit_allocator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .alloc_size_i   (alloc_size_i),
    .start_offset_i (start_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_o           (ok_o),
    .block_offset_o (block_offset_o),
    .freed_count_o  (freed_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(200_000_000);
    $display("tb: failure");
    $finish;
  end

  // result side: check beats, stall in random bursts
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) sb.check_result(ok_o, block_offset_o, freed_count_o);
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left  <= $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_beat(logic [1:0] req, logic [CW-1:0] size, logic [AW-1:0] start);
    alloc_result_t r;
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    alloc_size_i   <= size;
    start_offset_i <= start;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    r = sb.note_request(req, size, start);
    items_sent++;
    if (req == REQ_ALLOC && r.ok && size != 0) live_offs.push_back(r.offs);
    if (req == REQ_CLEAR) live_offs.delete();
  endtask

  task automatic idle_in(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [12:0] v);
    idle_in(1);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_pool(v);
    @(posedge clk_i);
  endtask

  task automatic random_beats(int count);
    logic [1:0]    req;
    logic [CW-1:0] size;
    logic [AW-1:0] start;
    int unsigned   pick;
    int unsigned   n;
    int            idx;
    for (int j = 0; j < count; j++) begin
      n = sb.usable();
      pick = $urandom_range(0, 99);
      if (pick < 55) req = REQ_ALLOC;
      else if (pick < 92) req = REQ_FREE;
      else if (pick < 95) req = REQ_CLEAR;
      else req = REQ_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 70) size = CW'($urandom_range(0, (n / 8 > 0) ? n / 8 : 1));
      else if (pick < 88) size = CW'($urandom_range(0, n + 2));
      else size = CW'($urandom_range(0, 8191));
      if (live_offs.size() != 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, live_offs.size() - 1);
        start = AW'(live_offs[idx]);
        live_offs.delete(idx);
      end else begin
        start = AW'($urandom_range(0, 4095));
      end
      send_beat(req, size, start);
      if (!quiet && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 14));
      if (j == count / 2 && !quiet) begin
        idle_in(1);
        wait_drained();
      end
    end
  endtask

  initial begin
    sb = new();
    sb.set_pool(13'd4096);
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_ALLOC;
    alloc_size_i   = '0;
    start_offset_i = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    quiet          = 0;
    items_sent     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every request code, odd cases
    send_beat(REQ_ALLOC, 13'd0, 12'd0);
    send_beat(REQ_ALLOC, 13'd1, 12'd0);
    send_beat(REQ_ALLOC, 13'd0, 12'd0);
    send_beat(REQ_ALLOC, 13'd5, 12'd0);
    send_beat(REQ_FREE, 13'd0, 12'd0);
    send_beat(REQ_FREE, 13'd0, 12'd0);
    send_beat(REQ_ALLOC, 13'd8191, 12'd4095);
    send_beat(REQ_ALLOC, 13'd4096, 12'd0);
    send_beat(REQ_UNUSED, 13'd8191, 12'd4095);
    send_beat(REQ_FREE, 13'd0, 12'd4095);
    send_beat(REQ_FREE, 13'd0, 12'd8);
    send_beat(REQ_CLEAR, 13'd0, 12'd0);
    send_beat(REQ_ALLOC, 13'd4096, 12'd0);
    send_beat(REQ_ALLOC, 13'd1, 12'd0);
    send_beat(REQ_FREE, 13'd0, 12'd0);
    send_beat(REQ_ALLOC, 13'd4095, 12'd0);
    send_beat(REQ_FREE, 13'd0, 12'd1);
    send_beat(REQ_CLEAR, 13'd0, 12'd0);
    write_pool(13'd0);
    send_beat(REQ_ALLOC, 13'd0, 12'd0);
    send_beat(REQ_FREE, 13'd0, 12'd0);
    write_pool(13'd1);
    send_beat(REQ_ALLOC, 13'd1, 12'd0);
    send_beat(REQ_ALLOC, 13'd0, 12'd0);
    send_beat(REQ_FREE, 13'd0, 12'd0);
    write_pool(13'd8191);
    send_beat(REQ_ALLOC, 13'd3, 12'd0);
    write_pool(13'd16);
    send_beat(REQ_ALLOC, 13'd15, 12'd0);
    send_beat(REQ_ALLOC, 13'd16, 12'd0);
    write_pool(13'd4096);
    send_beat(REQ_FREE, 13'd0, 12'd0);
    idle_in(1);

    // random phases over several pool sizes
    write_pool(13'd64);   random_beats(80);
    write_pool(13'd37);   random_beats(60);
    write_pool(13'd1);    random_beats(20);
    write_pool(13'd0);    random_beats(15);
    write_pool(13'd256);  random_beats(80);
    write_pool(13'd8191); random_beats(40);
    write_pool(13'd100);  random_beats(80);
    write_pool(13'd4096); random_beats(30);
    write_pool(13'd128);
    quiet = 1;
    random_beats(70);
    idle_in(1);

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d requests and %0d result beats over pool sizes 0 to 8191,",
             items_sent, sb.results_seen);
    $display("with allocate, free, clear and unused codes; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
